@@ src/nvadm_pkg.sv @@
// ----------------------------------------------------------------------------
// nvadm_pkg: shared types and constants
// Register map, operation and result codes, stream widths and helpers for the
// NVMe-style admin register endpoint.
// ----------------------------------------------------------------------------
package nvadm_pkg;

	localparam logic [63:0] MMIO_WINDOW_BYTES = 64'd65536;
	localparam int WIN_W = $clog2(MMIO_WINDOW_BYTES + 64'd1);

	localparam int S_TDATA_W = 296;
	localparam int M_TDATA_W = 272;
	localparam int USER_W    = 3;

	localparam logic [63:0] REG_CAP  = 64'h0000;
	localparam logic [63:0] REG_CC   = 64'h0014;
	localparam logic [63:0] REG_CSTS = 64'h001C;
	localparam logic [63:0] REG_AQA  = 64'h0024;
	localparam logic [63:0] REG_ASQ  = 64'h0028;
	localparam logic [63:0] REG_ACQ  = 64'h0030;
	localparam logic [63:0] REG_DB0  = 64'h1000;
	localparam logic [31:0] CAP_VALUE = 32'h0000_0001;

	localparam logic [63:0] CPL_BEAT0 = 64'hC7C6C5C4C3C2C1C0;
	localparam logic [63:0] CPL_BEAT1 = 64'hCFCECDCCCBCAC9C8;

	localparam logic [63:0] TS_HOST_STEP  = 64'd15;
	localparam logic [63:0] TS_DOORBELL   = 64'd60;
	localparam logic [63:0] TS_READ_RSP   = 64'd45;
	localparam logic [63:0] TS_WRITE_RSP  = 64'd30;
	localparam logic [63:0] TS_RESET_VAL  = 64'd100;
	localparam logic [63:0] TXN_RESET_VAL = 64'd1;

	localparam logic [6:0] DMA_RD_BYTES = 7'd64;
	localparam logic [6:0] BEAT_BYTES   = 7'd8;

	localparam logic [2:0] OP_RESET = 3'd0;
	localparam logic [2:0] OP_WRITE = 3'd1;
	localparam logic [2:0] OP_READ  = 3'd2;
	localparam logic [2:0] OP_DRSP  = 3'd3;
	localparam logic [2:0] OP_WRSP  = 3'd4;

	localparam logic [2:0] KIND_RESET_ACK = 3'd0;
	localparam logic [2:0] KIND_WRITE_ACK = 3'd1;
	localparam logic [2:0] KIND_READ_DATA = 3'd2;
	localparam logic [2:0] KIND_DMA_RD    = 3'd3;
	localparam logic [2:0] KIND_DMA_WR    = 3'd4;
	localparam logic [2:0] KIND_MSIX      = 3'd5;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_INV_ADDR = 2'd1;
	localparam logic [1:0] ST_BAD_LEN  = 2'd2;

	localparam logic [1:0] PH_IDLE = 2'd0;
	localparam logic [1:0] PH_RD   = 2'd1;
	localparam logic [1:0] PH_WR   = 2'd2;

	typedef struct packed {
		logic [2:0]  op;
		logic [63:0] txn_id;
		logic [63:0] address;
		logic [63:0] write_data;
		logic [31:0] length;
		logic [6:0]  be_count;
		logic        response_ok;
	} item_t;

	typedef struct packed {
		logic [2:0]  kind;
		logic [63:0] result_txn;
		logic [63:0] result_address;
		logic [1:0]  status;
		logic [63:0] data;
		logic [6:0]  data_bytes;
		logic [63:0] sim_time;
		logic        last;
	} result_t;

	typedef struct packed {
		logic load;
		logic two;
	} load_t;

	function automatic logic in_window(input logic [63:0] addr, input logic [31:0] len);
		logic        addr_ok;
		logic [32:0] sum;
		addr_ok = (addr <= MMIO_WINDOW_BYTES);
		sum = {1'b0, len} + 33'(addr[WIN_W-1:0]);
		return addr_ok && (sum <= 33'(MMIO_WINDOW_BYTES));
	endfunction

endpackage

@@ src/nvme_like_admin_register_endpoint_top.sv @@
// ----------------------------------------------------------------------------
// nvme_like_admin_register_endpoint_top: NVMe-style admin register endpoint
// Usage:
//  s_axis carries bus items: tuser is the op code, tdata the item fields.
//  m_axis carries result items: tuser is the result kind, tlast marks the
//  final result caused by one input item.
//  An accepted item is held in the input register, then is decoded and
//  its results are loaded into a two-entry result buffer, from which the
//  first result is offered.
//  Items with one result run at one item per cycle while m_axis does not
//  stall; items with two results (doorbell, DMA read response) are paced
//  by the single output port draining the result buffer. Items without a
//  result never wait for buffer space.
//  When m_axis stalls the buffer holds its results and s_axis_tready drops
//  once the input register is full.
//  Reset initialises the control registers (not the data registers): time
//  stamp 100, next transaction id 1, no DMA chain running, no result pending.
// ----------------------------------------------------------------------------
module nvme_like_admin_register_endpoint_top import nvadm_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_axis_tvalid,
	output logic                 s_axis_tready,
	// txn_id, address, write_data, length, be_mask, response_ok
	input  logic [S_TDATA_W-1:0] s_axis_tdata,
	// op
	input  logic [USER_W-1:0]    s_axis_tuser,
	output logic                 m_axis_tvalid,
	input  logic                 m_axis_tready,
	// result_txn, result_address, status, data, data_bytes, sim_time
	output logic [M_TDATA_W-1:0] m_axis_tdata,
	// kind
	output logic [USER_W-1:0]    m_axis_tuser,
	output logic                 m_axis_tlast
);

	item_t   in_item, item;
	logic    item_valid, take, space;
	load_t   ld;
	result_t res0, res1, out_res;

	always_comb begin
		in_item             = '0;
		in_item.op          = s_axis_tuser;
		in_item.txn_id      = s_axis_tdata[63:0];
		in_item.address     = s_axis_tdata[127:64];
		in_item.write_data  = s_axis_tdata[191:128];
		in_item.length      = s_axis_tdata[223:192];
		in_item.response_ok = s_axis_tdata[288];
	end

	nvadm_in_reg u_in_reg (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_axis_tvalid),
		.in_ready   (s_axis_tready),
		.in_item    (in_item),
		.in_be      (s_axis_tdata[287:224]),
		.take       (take),
		.item_valid (item_valid),
		.item       (item)
	);

	nvadm_core u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item       (item),
		.space      (space),
		.take       (take),
		.ld         (ld),
		.res0       (res0),
		.res1       (res1)
	);

	nvadm_out_buf u_out_buf (
		.clk       (clk),
		.arst_n    (arst_n),
		.ld        (ld),
		.res0      (res0),
		.res1      (res1),
		.space     (space),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_res   (out_res)
	);

	assign m_axis_tdata = {7'd0, out_res.sim_time, out_res.data_bytes, out_res.data,
		out_res.status, out_res.result_address, out_res.result_txn};
	assign m_axis_tuser = out_res.kind;
	assign m_axis_tlast = out_res.last;

endmodule

@@ src/nvadm_in_reg.sv @@
// ----------------------------------------------------------------------------
// nvadm_in_reg: input register
// Captures one input transfer and precomputes the byte-enable count.
// ----------------------------------------------------------------------------
module nvadm_in_reg import nvadm_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  item_t       in_item,
	input  logic [63:0] in_be,
	input  logic        take,
	output logic        item_valid,
	output item_t       item
);

	logic  valid_s1;
	item_t item_s1;
	item_t cap_item;

	assign in_ready   = !valid_s1 || take;
	assign item_valid = valid_s1;
	assign item       = item_s1;

	always_comb begin
		cap_item          = in_item;
		cap_item.be_count = 7'($countones(in_be));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			valid_s1 <= 1'b1;
		end else if (take) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= cap_item;
		end
	end

endmodule

@@ src/nvadm_core.sv @@
// ----------------------------------------------------------------------------
// nvadm_core: register file and DMA chain sequencer
// Decodes the registered item, updates controller state and forms up to two
// result items in one pass.
// ----------------------------------------------------------------------------
module nvadm_core import nvadm_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    item_valid,
	input  item_t   item,
	input  logic    space,
	output logic    take,
	output load_t   ld,
	output result_t res0,
	output result_t res1
);

	logic [31:0] cc_q, cc_n;
	logic        rdy_q, rdy_n;
	logic [63:0] sq_q, sq_n;
	logic [63:0] cq_q, cq_n;
	logic [31:0] aqa_q, aqa_n;
	logic [1:0]  phase_q, phase_n;
	logic [63:0] await_q, await_n;
	logic [63:0] txn_cnt_q, txn_cnt_n;
	logic [63:0] ts_q, ts_n;

	logic [63:0] ts_host, ts_db, ts_rd, ts_wr;
	logic [63:0] txn_inc;
	logic [1:0]  n_res;
	logic        wr_win, ring;
	logic [1:0]  wr_st;
	logic [31:0] eff_len, rd_len, rd_val;
	logic [1:0]  rd_st;
	logic        rd_bad;
	logic        dma_match;

	assign ts_host = ts_q + TS_HOST_STEP;
	assign ts_db   = ts_host + TS_DOORBELL;
	assign ts_rd   = ts_q + TS_READ_RSP;
	assign ts_wr   = ts_q + TS_WRITE_RSP;
	assign txn_inc = txn_cnt_q + 64'd1;

	assign take    = item_valid && ((n_res == 2'd0) || space);
	assign ld.load = item_valid && (n_res != 2'd0) && space;
	assign ld.two  = (n_res == 2'd2);

	always_comb begin
		cc_n      = cc_q;
		rdy_n     = rdy_q;
		sq_n      = sq_q;
		cq_n      = cq_q;
		aqa_n     = aqa_q;
		phase_n   = phase_q;
		await_n   = await_q;
		txn_cnt_n = txn_cnt_q;
		ts_n      = ts_q;
		n_res     = 2'd0;
		res0      = '0;
		res1      = '0;
		wr_win    = in_window(item.address, item.length);
		ring      = 1'b0;
		wr_st     = ST_OK;
		eff_len   = (item.length == 32'd0) ? 32'(item.be_count) : item.length;
		rd_bad    = !(eff_len == 32'd1 || eff_len == 32'd2 || eff_len == 32'd4 ||
			eff_len == 32'd8);
		rd_len    = rd_bad ? 32'd0 : eff_len;
		rd_st     = rd_bad ? ST_BAD_LEN : ST_OK;
		rd_val    = 32'd0;
		dma_match = (item.txn_id == await_q);

		case (item.op)
			OP_RESET: begin
				ts_n             = ts_host;
				cc_n             = 32'd0;
				rdy_n            = 1'b0;
				sq_n             = 64'd0;
				cq_n             = 64'd0;
				aqa_n            = 32'd0;
				n_res            = 2'd1;
				res0.kind        = KIND_RESET_ACK;
				res0.result_txn  = item.txn_id;
				res0.sim_time    = ts_host;
				res0.last        = 1'b1;
			end
			OP_WRITE: begin
				if (!wr_win) begin
					wr_st = ST_INV_ADDR;
				end else if (item.address == REG_CC && item.length == 32'd4) begin
					cc_n  = item.write_data[31:0];
					rdy_n = item.write_data[0];
				end else if (item.address == REG_ASQ && item.length == 32'd8) begin
					sq_n = item.write_data;
				end else if (item.address == REG_ACQ && item.length == 32'd8) begin
					cq_n = item.write_data;
				end else if (item.address == REG_AQA && item.length == 32'd4) begin
					aqa_n = item.write_data[31:0];
				end else if (item.address == REG_DB0 && item.length == 32'd4) begin
					ring = 1'b1;
				end else if (item.length != 32'd4 && item.length != 32'd8) begin
					wr_st = ST_BAD_LEN;
				end else begin
					wr_st = ST_INV_ADDR;
				end
				res0.kind           = KIND_WRITE_ACK;
				res0.result_txn     = item.txn_id;
				res0.result_address = item.address;
				res0.status         = wr_st;
				res0.sim_time       = ts_host;
				if (ring && phase_q == PH_IDLE) begin
					n_res               = 2'd2;
					res0.last           = 1'b0;
					res1.kind           = KIND_DMA_RD;
					res1.result_txn     = txn_cnt_q;
					res1.result_address = sq_q;
					res1.data_bytes     = DMA_RD_BYTES;
					res1.sim_time       = ts_db;
					res1.last           = 1'b1;
					await_n             = txn_cnt_q;
					txn_cnt_n           = txn_inc;
					phase_n             = PH_RD;
					ts_n                = ts_db;
				end else begin
					n_res     = 2'd1;
					res0.last = 1'b1;
					ts_n      = ts_host;
				end
			end
			OP_READ: begin
				ts_n = ts_host;
				if (!in_window(item.address, rd_len)) begin
					rd_st = ST_INV_ADDR;
				end else if (item.address == REG_CSTS) begin
					rd_val = {31'd0, rdy_q};
				end else if (item.address == REG_CC) begin
					rd_val = cc_q;
				end else if (item.address == REG_AQA) begin
					rd_val = aqa_q;
				end else if (item.address == REG_CAP) begin
					rd_val = CAP_VALUE;
				end else begin
					rd_st = ST_INV_ADDR;
				end
				n_res               = 2'd1;
				res0.kind           = KIND_READ_DATA;
				res0.result_txn     = item.txn_id;
				res0.result_address = item.address;
				res0.status         = rd_st;
				res0.sim_time       = ts_host;
				res0.last           = 1'b1;
				if (rd_st == ST_OK) begin
					res0.data_bytes = rd_len[6:0];
					case (rd_len[3:0])
						4'd1:    res0.data = {56'd0, rd_val[7:0]};
						4'd2:    res0.data = {48'd0, rd_val[15:0]};
						default: res0.data = {32'd0, rd_val};
					endcase
				end
			end
			OP_DRSP: begin
				if (phase_q == PH_RD && dma_match) begin
					if (!item.response_ok) begin
						phase_n = PH_IDLE;
					end else begin
						ts_n                = ts_rd;
						await_n             = txn_cnt_q;
						txn_cnt_n           = txn_inc;
						phase_n             = PH_WR;
						n_res               = 2'd2;
						res0.kind           = KIND_DMA_WR;
						res0.result_txn     = txn_cnt_q;
						res0.result_address = cq_q;
						res0.data           = CPL_BEAT0;
						res0.data_bytes     = BEAT_BYTES;
						res0.sim_time       = ts_rd;
						res1                = res0;
						res1.data           = CPL_BEAT1;
						res1.last           = 1'b1;
					end
				end
			end
			OP_WRSP: begin
				if (phase_q == PH_WR && dma_match) begin
					phase_n = PH_IDLE;
					if (item.response_ok) begin
						ts_n            = ts_wr;
						txn_cnt_n       = txn_inc;
						n_res           = 2'd1;
						res0.kind       = KIND_MSIX;
						res0.result_txn = txn_cnt_q;
						res0.sim_time   = ts_wr;
						res0.last       = 1'b1;
					end
				end
			end
			default: begin
				ts_n = ts_host;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cc_q      <= 32'd0;
			rdy_q     <= 1'b0;
			sq_q      <= 64'd0;
			cq_q      <= 64'd0;
			aqa_q     <= 32'd0;
			phase_q   <= PH_IDLE;
			await_q   <= 64'd0;
			txn_cnt_q <= TXN_RESET_VAL;
			ts_q      <= TS_RESET_VAL;
		end else if (take) begin
			cc_q      <= cc_n;
			rdy_q     <= rdy_n;
			sq_q      <= sq_n;
			cq_q      <= cq_n;
			aqa_q     <= aqa_n;
			phase_q   <= phase_n;
			await_q   <= await_n;
			txn_cnt_q <= txn_cnt_n;
			ts_q      <= ts_n;
		end
	end

	a_idle_stable: assert property (@(posedge clk) disable iff (!arst_n)
		!take |=> $stable(ts_q) && $stable(txn_cnt_q) && $stable(phase_q))
		else $error("core state changed without an item");

	a_chain_start: assert property (@(posedge clk) disable iff (!arst_n)
		(ld.load && ld.two && item.op == OP_WRITE) |=> phase_q == PH_RD)
		else $error("doorbell pair without read phase");

endmodule

@@ src/nvadm_out_buf.sv @@
// ----------------------------------------------------------------------------
// nvadm_out_buf: result register
// Two-entry result buffer; presents results one transfer at a time.
// ----------------------------------------------------------------------------
module nvadm_out_buf import nvadm_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  load_t   ld,
	input  result_t res0,
	input  result_t res1,
	output logic    space,
	output logic    out_valid,
	input  logic    out_ready,
	output result_t out_res
);

	result_t     r0_q, r1_q;
	logic [1:0]  cnt_q;
	logic        pop;

	assign out_valid = (cnt_q != 2'd0);
	assign out_res   = r0_q;
	assign pop       = out_valid && out_ready;
	assign space     = (cnt_q == 2'd0) || (cnt_q == 2'd1 && pop);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else if (ld.load) begin
			cnt_q <= ld.two ? 2'd2 : 2'd1;
		end else if (pop) begin
			cnt_q <= cnt_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (ld.load) begin
			r0_q <= res0;
			r1_q <= res1;
		end else if (pop) begin
			r0_q <= r1_q;
		end
	end

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q != 2'd3)
		else $error("result count overflow");

	a_pair_held: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_res.last) |-> cnt_q == 2'd2)
		else $error("first result of a pair without its partner");

	a_pop_count: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && !ld.load) |=> cnt_q == 2'($past(cnt_q) - 2'd1))
		else $error("result count not decremented on transfer");

endmodule
